// ----- design/vt52_pkg.sv -----
// Shared types, codes and display-operation helpers for the VT52 escape decoder.
package vt52_pkg;

  localparam int MAX_OPS = 5;

  localparam logic [2:0] OP_GLYPH       = 3'd0;
  localparam logic [2:0] OP_XOR         = 3'd1;
  localparam logic [2:0] OP_SCROLL_UP   = 3'd2;
  localparam logic [2:0] OP_SCROLL_DOWN = 3'd3;
  localparam logic [2:0] OP_ERASE       = 3'd4;
  localparam logic [2:0] OP_BELL        = 3'd5;

  localparam logic [1:0] REG_MAX_COLUMN  = 2'd0;
  localparam logic [1:0] REG_MAX_ROW     = 2'd1;
  localparam logic [1:0] REG_BELL_ENABLE = 2'd2;

  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_HT  = 8'd9;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_Y   = 8'h59;
  localparam logic [7:0] CH_LB  = 8'h62;
  localparam logic [7:0] CH_LC  = 8'h63;

  // escape sequence letters
  localparam logic [7:0] SEQ_UP        = "A";
  localparam logic [7:0] SEQ_DOWN      = "B";
  localparam logic [7:0] SEQ_RIGHT     = "C";
  localparam logic [7:0] SEQ_LEFT      = "D";
  localparam logic [7:0] SEQ_CLEAR     = "E";
  localparam logic [7:0] SEQ_HOME      = "H";
  localparam logic [7:0] SEQ_REV_LF    = "I";
  localparam logic [7:0] SEQ_ERASE_EOS = "J";
  localparam logic [7:0] SEQ_ERASE_EOL = "K";
  localparam logic [7:0] SEQ_INS_LINE  = "L";
  localparam logic [7:0] SEQ_DEL_LINE  = "M";
  localparam logic [7:0] SEQ_ERASE_SOS = "d";
  localparam logic [7:0] SEQ_CUR_ON    = "e";
  localparam logic [7:0] SEQ_CUR_OFF   = "f";
  localparam logic [7:0] SEQ_SAVE      = "j";
  localparam logic [7:0] SEQ_RESTORE   = "k";
  localparam logic [7:0] SEQ_ERASE_LN  = "l";
  localparam logic [7:0] SEQ_ERASE_SOL = "o";
  localparam logic [7:0] SEQ_INV_ON    = "p";
  localparam logic [7:0] SEQ_INV_OFF   = "q";
  localparam logic [7:0] SEQ_WRAP_ON   = "v";
  localparam logic [7:0] SEQ_WRAP_OFF  = "w";

  typedef enum logic [2:0] {
    MODE_NORMAL, MODE_ESC, MODE_YROW, MODE_YCOL, MODE_FG, MODE_BG
  } mode_t;

  typedef enum logic [3:0] {
    K_NONE, K_TICK, K_PRINT, K_CTRL, K_ESC, K_YROW, K_YCOL, K_FG, K_BG
  } kind_t;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] col_a;
    logic [7:0] row_a;
    logic [7:0] col_b;
    logic [7:0] row_b;
    logic [7:0] glyph;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
    logic       last;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } q_item_t;

  // working copy of cursor state plus the operation list built for one item
  typedef struct packed {
    out_item_t [MAX_OPS-1:0] ops;
    logic [2:0]              cnt;
    logic [7:0]              hc;
    logic                    shown;
    logic                    en;
    logic [7:0]              col;
    logic [7:0]              row;
  } ctx_t;

  function automatic ctx_t f_emit(ctx_t c, logic [2:0] op, logic [7:0] ca, logic [7:0] ra,
                                  logic [7:0] cb, logic [7:0] rb, logic [7:0] g,
                                  logic [3:0] fg, logic [3:0] bg);
    ctx_t r;
    r = c;
    if (c.cnt < 3'(MAX_OPS)) begin
      r.ops[c.cnt] = '{op: op, col_a: ca, row_a: ra, col_b: cb, row_b: rb, glyph: g,
                       fg_index: fg, bg_index: bg, last: 1'b0};
      r.cnt = c.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic ctx_t f_xor(ctx_t c);
    return f_emit(c, OP_XOR, c.col, c.row, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0);
  endfunction

  function automatic ctx_t f_erase(ctx_t c, logic [7:0] c1, logic [7:0] r1,
                                   logic [7:0] c2, logic [7:0] r2);
    return f_emit(c, OP_ERASE, c1, r1, c2, r2, 8'd0, 4'd0, 4'd0);
  endfunction

  // no scroll when the start row is at or below the bottom
  function automatic ctx_t f_scroll(ctx_t c, logic [2:0] op, logic [7:0] start,
                                    logic [7:0] maxr);
    ctx_t r;
    r = c;
    if (start < maxr) r = f_emit(c, op, 8'd0, start, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0);
    return r;
  endfunction

  function automatic ctx_t f_hide(ctx_t c);
    ctx_t r;
    r = c;
    if (r.hc != 8'hff) r.hc = r.hc + 8'd1;
    if (r.shown && r.en) begin
      r = f_xor(r);
      r.shown = 1'b0;
    end
    return r;
  endfunction

  function automatic ctx_t f_show(ctx_t c);
    ctx_t r;
    r = c;
    if (r.hc != 8'd0) r.hc = r.hc - 8'd1;
    if (r.hc == 8'd0 && r.en && !r.shown) begin
      r = f_xor(r);
      r.shown = 1'b1;
    end
    return r;
  endfunction

  function automatic ctx_t f_move(ctx_t c, logic signed [9:0] x, logic signed [9:0] y,
                                  logic [7:0] maxc, logic [7:0] maxr);
    ctx_t r;
    logic [7:0] nx;
    logic [7:0] ny;
    if (x < 10'sd0) nx = 8'd0;
    else if (x > $signed({2'b00, maxc})) nx = maxc;
    else nx = x[7:0];
    if (y < 10'sd0) ny = 8'd0;
    else if (y > $signed({2'b00, maxr})) ny = maxr;
    else ny = y[7:0];
    r = f_hide(c);
    r.col = nx;
    r.row = ny;
    r = f_show(r);
    return r;
  endfunction

endpackage

// ----- design/vt52_front.sv -----
// Front end: tracks the escape parse mode and classifies each accepted item.
module vt52_front import vt52_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output q_item_t  q_wdata
);

  mode_t mode_r, mode_nxt;
  kind_t kind;

  assign in_ready = ~q_full;
  assign q_push   = in_valid & in_ready;
  assign q_wdata  = '{kind: kind, data: in_item.byte_in};

  always_comb begin
    mode_nxt = mode_r;
    if (!in_item.command) begin
      case (mode_r)
        MODE_NORMAL: mode_nxt = (in_item.byte_in == CH_ESC) ? MODE_ESC : MODE_NORMAL;
        MODE_ESC: begin
          case (in_item.byte_in)
            CH_Y:    mode_nxt = MODE_YROW;
            CH_LB:   mode_nxt = MODE_FG;
            CH_LC:   mode_nxt = MODE_BG;
            default: mode_nxt = MODE_NORMAL;
          endcase
        end
        MODE_YROW: mode_nxt = MODE_YCOL;
        default:   mode_nxt = MODE_NORMAL;
      endcase
    end
  end

  always_comb begin
    kind = K_NONE;
    if (in_item.command) begin
      kind = K_TICK;
    end else begin
      case (mode_r)
        MODE_ESC:  kind = K_ESC;
        MODE_YROW: kind = K_YROW;
        MODE_YCOL: kind = K_YCOL;
        MODE_FG:   kind = K_FG;
        MODE_BG:   kind = K_BG;
        default: begin
          if (in_item.byte_in > 8'd31) kind = K_PRINT;
          else if (in_item.byte_in inside {[CH_BEL:CH_CR]}) kind = K_CTRL;
          else kind = K_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_NORMAL;
    else if (q_push) mode_r <= mode_nxt;
  end

endmodule

// ----- design/vt52_fifo.sv -----
// Two-entry queue between the classifier and the executor.
module vt52_fifo import vt52_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wdata,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output q_item_t rdata
);

  q_item_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- design/vt52_back.sv -----
// Back end: executes classified items on the cursor state and emits display operations.
module vt52_back import vt52_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] maxc_r, maxr_r;
  logic       bell_r;
  logic [7:0] col_r, row_r, sv_col_r, sv_row_r, hc_r;
  logic [8:0] pend_r;
  logic [3:0] fg_r, bg_r;
  logic       wrap_r, inv_r, en_r, shown_r;

  logic [7:0] sv_col_nxt, sv_row_nxt;
  logic [8:0] pend_nxt;
  logic [3:0] fg_nxt, bg_nxt;
  logic       wrap_nxt, inv_nxt;

  out_item_t [MAX_OPS-1:0] ops_r;
  logic [2:0] cnt_r, idx_r;
  ctx_t       c;
  logic       free;

  assign out_valid = (idx_r != cnt_r);
  assign free = !out_valid || (out_ready && idx_r == cnt_r - 3'd1);
  assign q_pop = free && q_valid;

  always_comb begin
    out_item = '0;
    if (idx_r < 3'(MAX_OPS)) out_item = ops_r[idx_r];
    out_item.last = (idx_r == cnt_r - 3'd1);
  end

  always_comb begin
    logic [7:0]        b;
    logic signed [9:0] t;
    logic [7:0]        cx, cy;
    b = q_item.data;
    t = '0;
    c = '0;
    c.hc = hc_r; c.shown = shown_r; c.en = en_r; c.col = col_r; c.row = row_r;
    cx = col_r; cy = row_r;
    sv_col_nxt = sv_col_r; sv_row_nxt = sv_row_r; pend_nxt = pend_r;
    fg_nxt = fg_r; bg_nxt = bg_r; wrap_nxt = wrap_r; inv_nxt = inv_r;
    case (q_item.kind)
      K_TICK: begin
        if (hc_r == 8'd0 && en_r) begin
          c = f_xor(c);
          c.shown = ~shown_r;
        end
      end
      K_PRINT: begin
        c = f_hide(c);
        if (inv_r) c = f_emit(c, OP_GLYPH, cx, cy, 8'd0, 8'd0, b, bg_r, fg_r);
        else c = f_emit(c, OP_GLYPH, cx, cy, 8'd0, 8'd0, b, fg_r, bg_r);
        t = $signed({2'b00, cx}) + 10'sd1;
        if (t > $signed({2'b00, maxc_r})) begin
          if (wrap_r) begin
            t = '0;
            if ({1'b0, cy} + 9'd1 > {1'b0, maxr_r}) begin
              c = f_scroll(c, OP_SCROLL_UP, 8'd0, maxr_r);
              c = f_erase(c, 8'd0, maxr_r, maxc_r, maxr_r);
              c = f_move(c, t, $signed({2'b00, maxr_r}), maxc_r, maxr_r);
            end else begin
              c = f_move(c, t, $signed({2'b00, cy}) + 10'sd1, maxc_r, maxr_r);
            end
          end else begin
            c = f_move(c, $signed({2'b00, maxc_r}), $signed({2'b00, cy}), maxc_r, maxr_r);
          end
        end else begin
          c = f_move(c, t, $signed({2'b00, cy}), maxc_r, maxr_r);
        end
        c = f_show(c);
      end
      K_CTRL: begin
        c = f_hide(c);
        case (b)
          CH_BEL: if (bell_r) c = f_emit(c, OP_BELL, '0, '0, '0, '0, '0, '0, '0);
          CH_BS: begin
            if (cx != 8'd0)
              c = f_move(c, $signed({2'b00, cx}) - 10'sd1, $signed({2'b00, cy}),
                         maxc_r, maxr_r);
          end
          CH_HT: begin
            t = $signed({2'b00, cx & 8'hf8}) + 10'sd8;
            if (t > $signed({2'b00, maxc_r})) t = $signed({2'b00, maxc_r});
            c = f_move(c, t, $signed({2'b00, cy}), maxc_r, maxr_r);
          end
          CH_CR: c = f_move(c, 10'sd0, $signed({2'b00, cy}), maxc_r, maxr_r);
          default: begin
            // line feed, vertical tab and form feed
            t = $signed({2'b00, cy}) + 10'sd1;
            if (t > $signed({2'b00, maxr_r})) begin
              c = f_scroll(c, OP_SCROLL_UP, 8'd0, maxr_r);
              c = f_erase(c, 8'd0, maxr_r, maxc_r, maxr_r);
              t = $signed({2'b00, maxr_r});
            end
            c = f_move(c, $signed({2'b00, cx}), t, maxc_r, maxr_r);
          end
        endcase
        c = f_show(c);
      end
      K_ESC: begin
        case (b)
          SEQ_UP: if (cy != 8'd0)
            c = f_move(c, $signed({2'b00, cx}), $signed({2'b00, cy}) - 10'sd1, maxc_r, maxr_r);
          SEQ_DOWN: if ({1'b0, cy} + 9'd1 <= {1'b0, maxr_r})
            c = f_move(c, $signed({2'b00, cx}), $signed({2'b00, cy}) + 10'sd1, maxc_r, maxr_r);
          SEQ_RIGHT: if ({1'b0, cx} + 9'd1 <= {1'b0, maxc_r})
            c = f_move(c, $signed({2'b00, cx}) + 10'sd1, $signed({2'b00, cy}), maxc_r, maxr_r);
          SEQ_LEFT: if (cx != 8'd0)
            c = f_move(c, $signed({2'b00, cx}) - 10'sd1, $signed({2'b00, cy}), maxc_r, maxr_r);
          SEQ_CLEAR: begin
            c = f_hide(c);
            c = f_erase(c, 8'd0, 8'd0, maxc_r, maxr_r);
            c = f_move(c, 10'sd0, 10'sd0, maxc_r, maxr_r);
            c = f_show(c);
          end
          SEQ_HOME: c = f_move(c, 10'sd0, 10'sd0, maxc_r, maxr_r);
          SEQ_REV_LF: begin
            c = f_hide(c);
            if (cy == 8'd0) begin
              c = f_scroll(c, OP_SCROLL_DOWN, 8'd0, maxr_r);
              c = f_erase(c, 8'd0, 8'd0, maxc_r, 8'd0);
            end else begin
              c = f_move(c, $signed({2'b00, cx}), $signed({2'b00, cy}) - 10'sd1,
                         maxc_r, maxr_r);
            end
            c = f_show(c);
          end
          SEQ_ERASE_EOS: begin
            c = f_hide(c); c = f_erase(c, cx, cy, maxc_r, maxr_r); c = f_show(c);
          end
          SEQ_ERASE_EOL: begin
            c = f_hide(c); c = f_erase(c, cx, cy, maxc_r, cy); c = f_show(c);
          end
          SEQ_INS_LINE: begin
            c = f_hide(c);
            c = f_scroll(c, OP_SCROLL_DOWN, cy, maxr_r);
            c = f_erase(c, 8'd0, cy, maxc_r, cy);
            c = f_show(c);
          end
          SEQ_DEL_LINE: begin
            // delete line scrolls from the cursor row
            c = f_hide(c);
            c = f_scroll(c, OP_SCROLL_UP, cy, maxr_r);
            c = f_erase(c, 8'd0, maxr_r, maxc_r, maxr_r);
            c = f_show(c);
          end
          SEQ_ERASE_SOS: begin
            c = f_hide(c); c = f_erase(c, 8'd0, 8'd0, cx, cy); c = f_show(c);
          end
          SEQ_CUR_ON: begin
            c.en = 1'b1; c.hc = 8'd1; c = f_show(c);
          end
          SEQ_CUR_OFF: begin
            c = f_hide(c); c.en = 1'b0;
          end
          SEQ_SAVE: begin
            sv_col_nxt = cx; sv_row_nxt = cy;
          end
          SEQ_RESTORE: c = f_move(c, $signed({2'b00, sv_col_r}), $signed({2'b00, sv_row_r}),
                                  maxc_r, maxr_r);
          SEQ_ERASE_LN: begin
            c = f_hide(c);
            c = f_erase(c, 8'd0, cy, maxc_r, cy);
            c = f_move(c, 10'sd0, $signed({2'b00, cy}), maxc_r, maxr_r);
            c = f_show(c);
          end
          SEQ_ERASE_SOL: begin
            c = f_hide(c); c = f_erase(c, 8'd0, cy, cx, cy); c = f_show(c);
          end
          SEQ_INV_ON:   inv_nxt = 1'b1;
          SEQ_INV_OFF:  inv_nxt = 1'b0;
          SEQ_WRAP_ON:  wrap_nxt = 1'b1;
          SEQ_WRAP_OFF: wrap_nxt = 1'b0;
          default: ;
        endcase
      end
      K_YROW: pend_nxt = {1'b0, b} - 9'd32;
      K_YCOL: c = f_move(c, $signed({2'b00, b}) - 10'sd32, $signed({pend_r[8], pend_r}),
                         maxc_r, maxr_r);
      K_FG: fg_nxt = b[3:0];
      K_BG: bg_nxt = b[3:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) ops_r <= c.ops;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxc_r <= 8'd79; maxr_r <= 8'd24; bell_r <= 1'b1;
      col_r <= '0; row_r <= '0; sv_col_r <= '0; sv_row_r <= '0; pend_r <= '0;
      fg_r <= 4'd1; bg_r <= 4'd0; wrap_r <= 1'b0; inv_r <= 1'b0;
      en_r <= 1'b0; shown_r <= 1'b0; hc_r <= 8'd1;
      cnt_r <= '0; idx_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_COLUMN:  maxc_r <= cfg_data;
          REG_MAX_ROW:     maxr_r <= cfg_data;
          REG_BELL_ENABLE: bell_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (q_pop) begin
        col_r <= c.col; row_r <= c.row; hc_r <= c.hc; en_r <= c.en; shown_r <= c.shown;
        sv_col_r <= sv_col_nxt; sv_row_r <= sv_row_nxt; pend_r <= pend_nxt;
        fg_r <= fg_nxt; bg_r <= bg_nxt; wrap_r <= wrap_nxt; inv_r <= inv_nxt;
        cnt_r <= c.cnt;
        idx_r <= '0;
      end else if (out_valid && out_ready) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= cnt_r)
    else $error("op index beyond list");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(MAX_OPS))
    else $error("op list too long");
  a_op_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.op <= OP_BELL)
    else $error("bad op code");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("pop while op list pending");

endmodule

// ----- design/vt52_escape_parser_cursor_core.sv -----
// VT52 escape decoder core: a classifier feeds a two-entry queue that an executor
// drains. The executor turns each item into up to five display operations and sends
// them one per cycle while out_ready is high; the next item is taken from the queue in
// the cycle its predecessor's last operation is accepted. An accepted item is first
// written into the queue, then popped by the executor, whose operation list is
// registered before its first operation appears. Input is taken every cycle while the
// queue has room.
module vt52_escape_parser_cursor_core import vt52_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic    q_full, q_push, q_pop, q_valid;
  q_item_t q_wdata, q_rdata;

  vt52_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_full, .q_push, .q_wdata
  );

  vt52_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .rdata(q_rdata)
  );

  vt52_back u_back (
    .clk, .rst_n, .q_valid, .q_item(q_rdata), .q_pop,
    .out_valid, .out_ready, .out_item, .cfg_we, .cfg_index, .cfg_data
  );

endmodule
